@@ rtl/core/tkp_pkg.sv @@
// Shared widths, queue constants and the command type of the top-K peak finder.
`default_nettype none

package tkp_pkg;

  localparam int MASS_W      = 20;
  localparam int INTENSITY_W = 24;
  localparam int RANK_W      = 3;
  localparam int MAX_READOUT = 8;

  // Command queue between the detector and the peak list.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // One command for the peak list: an optional insertion of a confirmed
  // peak, then an optional readout of the whole list.
  typedef struct packed {
    logic                   do_insert;
    logic                   do_read;
    logic [MASS_W-1:0]      mass;
    logic [INTENSITY_W-1:0] intensity;
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } back_state_e;

endpackage

`default_nettype wire

@@ rtl/core/tkp_if.sv @@
// Valid/ready channel interfaces for spectrum samples and ranked peaks.
`default_nettype none

interface tkp_sample_if import tkp_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [MASS_W-1:0]      mass;
  logic [INTENSITY_W-1:0] intensity;
  logic                   last_sample;

  modport source (output valid, mass, intensity, last_sample, input ready);
  modport sink   (input valid, mass, intensity, last_sample, output ready);
endinterface

interface tkp_peak_if import tkp_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [MASS_W-1:0]      peak_mass;
  logic [INTENSITY_W-1:0] peak_intensity;
  logic [RANK_W-1:0]      rank;
  logic                   last_entry;

  modport source (output valid, peak_mass, peak_intensity, rank, last_entry, input ready);
  modport sink   (input valid, peak_mass, peak_intensity, rank, last_entry, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tkp_front.sv @@
// Local-maximum detector that turns accepted samples into peak list commands.
`default_nettype none

module tkp_front import tkp_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tkp_sample_if.sink  sample_i,
  input  wire logic   full_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  logic [MASS_W-1:0]      prev_mass_q, prev_mass_d;
  logic [INTENSITY_W-1:0] prev_int_q, prev_int_d;
  logic                   have_prev_q, have_prev_d;
  logic                   peak_taken_q, peak_taken_d;
  logic                   accept, rise, fall, insert;

  assign sample_i.ready = !full_i;
  assign accept         = sample_i.valid && sample_i.ready;

  assign rise   = have_prev_q && (prev_int_q < sample_i.intensity);
  assign fall   = have_prev_q && (prev_int_q > sample_i.intensity);
  assign insert = fall && !peak_taken_q;

  assign cmd_o.do_insert = insert;
  assign cmd_o.do_read   = sample_i.last_sample;
  assign cmd_o.mass      = prev_mass_q;
  assign cmd_o.intensity = prev_int_q;
  assign push_o          = accept && (insert || sample_i.last_sample);

  always_comb begin
    prev_mass_d  = prev_mass_q;
    prev_int_d   = prev_int_q;
    have_prev_d  = have_prev_q;
    peak_taken_d = peak_taken_q;
    if (accept) begin
      if (sample_i.last_sample) begin
        // The spectrum ends here: the detector starts over.
        prev_mass_d  = '0;
        prev_int_d   = '0;
        have_prev_d  = 1'b0;
        peak_taken_d = 1'b0;
      end else begin
        prev_mass_d = sample_i.mass;
        prev_int_d  = sample_i.intensity;
        have_prev_d = 1'b1;
        if (rise) begin
          peak_taken_d = 1'b0;
        end else if (insert) begin
          peak_taken_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_mass_q  <= '0;
      prev_int_q   <= '0;
      have_prev_q  <= 1'b0;
      peak_taken_q <= 1'b0;
    end else begin
      prev_mass_q  <= prev_mass_d;
      prev_int_q   <= prev_int_d;
      have_prev_q  <= have_prev_d;
      peak_taken_q <= peak_taken_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tkp_queue.sv @@
// Two-entry command queue between the detector and the peak list.
`default_nettype none

module tkp_queue import tkp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire cmd_t  cmd_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       head_valid_o,
  output cmd_t       head_o
);

  cmd_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o       = (count_q == QCNT_W'(QDEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("command pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !head_valid_o))
    else $error("command popped from an empty queue");

endmodule

`default_nettype wire

@@ rtl/core/tkp_back.sv @@
// Descending top-K peak list with insertion and ranked readout.
`default_nettype none

module tkp_back import tkp_pkg::*; #(
  parameter int PEAK_SLOTS = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   head_valid_i,
  input  wire cmd_t   head_i,
  output logic        pop_o,
  tkp_peak_if.source  peak_o
);

  localparam int                READOUT_COUNT = (PEAK_SLOTS < MAX_READOUT) ? PEAK_SLOTS
                                                                           : MAX_READOUT;
  localparam logic [RANK_W-1:0] RANK_LAST     = RANK_W'(READOUT_COUNT - 1);

  logic [MASS_W-1:0]      slot_mass_q [PEAK_SLOTS];
  logic [INTENSITY_W-1:0] slot_int_q  [PEAK_SLOTS];
  logic [PEAK_SLOTS-1:0]  beaten;

  back_state_e       state_q, state_d;
  logic [RANK_W-1:0] cnt_q;
  logic              do_ins, load, last_emit, shift_up, clear_list;

  logic                   out_valid_q;
  logic [MASS_W-1:0]      out_mass_q;
  logic [INTENSITY_W-1:0] out_int_q;
  logic [RANK_W-1:0]      out_rank_q;
  logic                   out_last_q;

  assign pop_o      = (state_q == S_IDLE) && head_valid_i;
  assign do_ins     = pop_o && head_i.do_insert;
  assign load       = (state_q == S_READ) && (!out_valid_q || peak_o.ready);
  assign last_emit  = (cnt_q == RANK_LAST);
  assign shift_up   = load && !last_emit;
  assign clear_list = load && last_emit;

  // Per-slot update: clear, shift up or insert. The list is descending, so the
  // slots that a new peak beats form a tail; the first of them takes the peak,
  // the rest take the entry above them.
  for (genvar g = 0; g < PEAK_SLOTS; g++) begin : g_slot
    logic [MASS_W-1:0]      above_mass, below_mass, mass_d;
    logic [INTENSITY_W-1:0] above_int, below_int, int_d;
    logic                   above_beaten;

    assign beaten[g] = slot_int_q[g] < head_i.intensity;

    if (g == 0) begin : g_top
      assign above_mass   = '0;
      assign above_int    = '0;
      assign above_beaten = 1'b0;
    end else begin : g_mid
      assign above_mass   = slot_mass_q[g-1];
      assign above_int    = slot_int_q[g-1];
      assign above_beaten = beaten[g-1];
    end

    if (g == PEAK_SLOTS - 1) begin : g_bottom
      assign below_mass = '0;
      assign below_int  = '0;
    end else begin : g_upper
      assign below_mass = slot_mass_q[g+1];
      assign below_int  = slot_int_q[g+1];
    end

    always_comb begin
      priority if (clear_list) begin
        mass_d = '0;
        int_d  = '0;
      end else if (shift_up) begin
        mass_d = below_mass;
        int_d  = below_int;
      end else if (do_ins && beaten[g]) begin
        mass_d = above_beaten ? above_mass : head_i.mass;
        int_d  = above_beaten ? above_int  : head_i.intensity;
      end else begin
        mass_d = slot_mass_q[g];
        int_d  = slot_int_q[g];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        slot_mass_q[g] <= '0;
        slot_int_q[g]  <= '0;
      end else begin
        slot_mass_q[g] <= mass_d;
        slot_int_q[g]  <= int_d;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (pop_o && head_i.do_read) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (clear_list) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        cnt_q <= last_emit ? '0 : cnt_q + 1'b1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (peak_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_mass_q <= slot_mass_q[0];
      out_int_q  <= slot_int_q[0];
      out_rank_q <= cnt_q;
      out_last_q <= last_emit;
    end
  end

  assign peak_o.valid          = out_valid_q;
  assign peak_o.peak_mass      = out_mass_q;
  assign peak_o.peak_intensity = out_int_q;
  assign peak_o.rank           = out_rank_q;
  assign peak_o.last_entry     = out_last_q;

  for (genvar g = 0; g < PEAK_SLOTS - 1; g++) begin : g_order_chk
    a_descending: assert property (@(posedge clk_i) disable iff (!rst_ni)
      slot_int_q[g] >= slot_int_q[g+1])
      else $error("peak list lost its descending order");
  end

  a_no_pop_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> !pop_o)
    else $error("command taken during readout");

  a_list_empty_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_list |=> (slot_int_q[0] == '0) && (state_q == S_IDLE))
    else $error("peak list not cleared after readout");

endmodule

`default_nettype wire

@@ rtl/core/top_k_spectrum_peak_finder_core.sv @@
// Top level of the top-K spectrum peak finder: detector, command queue and peak list.
`default_nettype none

// Channel   | Dir | Fields                                        | Transfer
// ----------+-----+-----------------------------------------------+------------------
// sample_i  | in  | mass, intensity, last_sample                  | valid && ready
// peak_o    | out | peak_mass, peak_intensity, rank, last_entry   | valid && ready
//
// Flow: the detector handles each sample transfer; a confirmed peak is one
//   insertion in the list, and a final sample adds, after any insertion,
//   min(PEAK_SLOTS, 8) readout results, one result per cycle from the list head while peak_o is not stalled.
// Reset: rst_ni clears the detector, the queue and every slot at once; no sweep.
// Stalls: sample_i.ready drops only while the two-entry command queue is full;
//   a stalled peak_o holds the readout and, through the queue, the input.

module top_k_spectrum_peak_finder_core import tkp_pkg::*; #(
  parameter int PEAK_SLOTS = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tkp_sample_if.sink  sample_i,
  tkp_peak_if.source  peak_o
);

  // The front end compares each sample with the one before it. A rise
  // re-arms the detector, and the first fall after arming confirms the
  // previous sample as a peak. Such peaks and end-of-spectrum readouts
  // become commands for the peak list.
  logic push;
  cmd_t push_cmd;
  logic queue_full;

  // The queue lets the detector keep taking samples while the list is busy
  // with an insertion or a readout.
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  tkp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_i),
    .full_i   (queue_full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  tkp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (push_cmd),
    .full_o       (queue_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_cmd)
  );

  // The back end keeps the descending list. An insertion runs in the cycle
  // its command is popped, so a peak confirmed by the final sample is in the
  // list before the readout that follows starts. The readout shifts the list
  // up one slot per result transfer and clears it with the last one.
  tkp_back #(
    .PEAK_SLOTS (PEAK_SLOTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .peak_o       (peak_o)
  );

endmodule

`default_nettype wire
